FILE: hdl/cpit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpit_pkg
// Shared widths, payload types and stage records of the circumcircle test.
// ----------------------------------------------------------------------------
package cpit_pkg;

  localparam int COORD_W    = 16;   // Q12.4 coordinate
  localparam int SQ_W       = 32;   // x^2 + y^2, unsigned
  localparam int DIF_W      = COORD_W + 1;
  localparam int PRD_W      = SQ_W + 1 + DIF_W;   // numerator product
  localparam int DPR_W      = COORD_W + DIF_W;    // denominator product
  localparam int NUM_W      = 52;
  localparam int DEN_W      = 36;
  localparam int QUO_W      = 32;
  localparam int DIV_STEPS  = 2;    // quotient bits per divider stage
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;
  localparam int CEN_W      = 32;
  localparam int MAG_W      = CEN_W + 1;
  localparam int SQD_W      = 2 * MAG_W;
  localparam int DST_W      = SQD_W + 1;
  localparam int CMP_W      = DST_W + 1;
  localparam int RAD_W      = 63;
  localparam int TOL_W      = 16;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // register byte address of the tolerance register
  localparam logic [APB_AW-1:0] REG_TOLERANCE = 3'd0;

  typedef logic signed [COORD_W-1:0] coord_t;

  // record carried through the divider stages
  typedef struct packed {
    logic                  zero;
    logic                  neg_x;
    logic                  neg_y;
    logic                  ovf_x;
    logic                  ovf_y;
    logic [DEN_W-1:0]      dmag;
    logic [DEN_W-1:0]      rem_x;
    logic [DEN_W-1:0]      rem_y;
    logic [QUO_W-1:0]      lo_x;
    logic [QUO_W-1:0]      lo_y;
    logic [QUO_W-1:0]      quo_x;
    logic [QUO_W-1:0]      quo_y;
    coord_t                ax;
    coord_t                ay;
    coord_t                qx;
    coord_t                qy;
  } div_t;

  // one finished result
  typedef struct packed {
    logic                     inside_res;
    logic                     in_band;
    logic                     degenerate;
    logic signed [CEN_W-1:0]  center_x;
    logic signed [CEN_W-1:0]  center_y;
    logic [RAD_W-1:0]         radius_squared;
  } res_t;

endpackage

FILE: hdl/cpit_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpit_in_if
// Input channel: triangle vertices and query point, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpit_in_if;
  logic            valid;
  logic            ready;
  cpit_pkg::coord_t vertex_a_x;
  cpit_pkg::coord_t vertex_a_y;
  cpit_pkg::coord_t vertex_b_x;
  cpit_pkg::coord_t vertex_b_y;
  cpit_pkg::coord_t vertex_c_x;
  cpit_pkg::coord_t vertex_c_y;
  cpit_pkg::coord_t query_x;
  cpit_pkg::coord_t query_y;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, query_x, query_y, input ready);
  modport sink   (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, query_x, query_y, output ready);
endinterface

FILE: hdl/cpit_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpit_out_if
// Result channel: decision flags, circumcenter and squared radius.
// ----------------------------------------------------------------------------
interface cpit_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  inside_res;
  logic                                  in_band;
  logic                                  degenerate;
  logic signed [cpit_pkg::CEN_W-1:0]     center_x;
  logic signed [cpit_pkg::CEN_W-1:0]     center_y;
  logic [cpit_pkg::RAD_W-1:0]            radius_squared;

  modport source (output valid, inside_res, in_band, degenerate, center_x,
                  center_y, radius_squared, input ready);
  modport sink   (input valid, inside_res, in_band, degenerate, center_x,
                  center_y, radius_squared, output ready);
endinterface

FILE: hdl/cpit_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpit_front
// Five stages: squares and differences, products, determinant sums,
// magnitudes, overflow check and divider seed.
// ----------------------------------------------------------------------------
module cpit_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  cpit_pkg::coord_t ax_i,
  input  cpit_pkg::coord_t ay_i,
  input  cpit_pkg::coord_t bx_i,
  input  cpit_pkg::coord_t by_i,
  input  cpit_pkg::coord_t cx_i,
  input  cpit_pkg::coord_t cy_i,
  input  cpit_pkg::coord_t qx_i,
  input  cpit_pkg::coord_t qy_i,
  output logic             out_valid,
  output cpit_pkg::div_t   out_rec
);

  // stage 1 registers
  logic                               v1_r;
  logic [cpit_pkg::SQ_W-1:0]          sqa_r, sqb_r, sqc_r;
  logic signed [cpit_pkg::DIF_W-1:0]  dycb_r, dyac_r, dyba_r, dxcb_r, dxac_r, dxba_r;
  cpit_pkg::coord_t                   ax1_r, ay1_r, bx1_r, cx1_r, qx1_r, qy1_r;
  // stage 2 registers
  logic                               v2_r;
  logic signed [cpit_pkg::PRD_W-1:0]  pxa_r, pxb_r, pxc_r, pya_r, pyb_r, pyc_r;
  logic signed [cpit_pkg::DPR_W-1:0]  pda_r, pdb_r, pdc_r;
  cpit_pkg::coord_t                   ax2_r, ay2_r, qx2_r, qy2_r;
  // stage 3 registers
  logic                               v3_r;
  logic signed [cpit_pkg::NUM_W-1:0]  nx_r, ny_r;
  logic signed [cpit_pkg::DEN_W-1:0]  den_r;
  cpit_pkg::coord_t                   ax3_r, ay3_r, qx3_r, qy3_r;
  // stage 4 registers
  logic                               v4_r;
  logic [cpit_pkg::NUM_W-1:0]         nmx_r, nmy_r;
  logic [cpit_pkg::DEN_W-1:0]         dm_r;
  logic                               negx_r, negy_r, zero_r;
  cpit_pkg::coord_t                   ax4_r, ay4_r, qx4_r, qy4_r;
  // stage 5 registers
  logic                               v5_r;
  cpit_pkg::div_t                     rec_r, rec_nxt;

  logic signed [cpit_pkg::NUM_W-1:0]  nx_nxt, ny_nxt;
  logic signed [cpit_pkg::DEN_W-1:0]  den_nxt;
  logic signed [cpit_pkg::DPR_W+1:0]  dsum;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: squared norms and coordinate differences
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r  <= cpit_pkg::SQ_W'(ax_i) * cpit_pkg::SQ_W'(ax_i)
                + cpit_pkg::SQ_W'(ay_i) * cpit_pkg::SQ_W'(ay_i);
      sqb_r  <= cpit_pkg::SQ_W'(bx_i) * cpit_pkg::SQ_W'(bx_i)
                + cpit_pkg::SQ_W'(by_i) * cpit_pkg::SQ_W'(by_i);
      sqc_r  <= cpit_pkg::SQ_W'(cx_i) * cpit_pkg::SQ_W'(cx_i)
                + cpit_pkg::SQ_W'(cy_i) * cpit_pkg::SQ_W'(cy_i);
      dycb_r <= cpit_pkg::DIF_W'(cy_i) - cpit_pkg::DIF_W'(by_i);
      dyac_r <= cpit_pkg::DIF_W'(ay_i) - cpit_pkg::DIF_W'(cy_i);
      dyba_r <= cpit_pkg::DIF_W'(by_i) - cpit_pkg::DIF_W'(ay_i);
      dxcb_r <= cpit_pkg::DIF_W'(cx_i) - cpit_pkg::DIF_W'(bx_i);
      dxac_r <= cpit_pkg::DIF_W'(ax_i) - cpit_pkg::DIF_W'(cx_i);
      dxba_r <= cpit_pkg::DIF_W'(bx_i) - cpit_pkg::DIF_W'(ax_i);
      ax1_r  <= ax_i;
      ay1_r  <= ay_i;
      bx1_r  <= bx_i;
      cx1_r  <= cx_i;
      qx1_r  <= qx_i;
      qy1_r  <= qy_i;
    end
  end

  // stage 2: determinant products
  always_ff @(posedge clk) begin
    if (en) begin
      pxa_r <= $signed({1'b0, sqa_r}) * dycb_r;
      pxb_r <= $signed({1'b0, sqb_r}) * dyac_r;
      pxc_r <= $signed({1'b0, sqc_r}) * dyba_r;
      pya_r <= $signed({1'b0, sqa_r}) * dxcb_r;
      pyb_r <= $signed({1'b0, sqb_r}) * dxac_r;
      pyc_r <= $signed({1'b0, sqc_r}) * dxba_r;
      pda_r <= ax1_r * dycb_r;
      pdb_r <= bx1_r * dyac_r;
      pdc_r <= cx1_r * dyba_r;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      qx2_r <= qx1_r;
      qy2_r <= qy1_r;
    end
  end

  // stage 3: sum the products
  always_comb begin
    nx_nxt  = cpit_pkg::NUM_W'(pxa_r) + cpit_pkg::NUM_W'(pxb_r) + cpit_pkg::NUM_W'(pxc_r);
    ny_nxt  = -(cpit_pkg::NUM_W'(pya_r) + cpit_pkg::NUM_W'(pyb_r)
                + cpit_pkg::NUM_W'(pyc_r));
    dsum    = (cpit_pkg::DPR_W+2)'(pda_r) + (cpit_pkg::DPR_W+2)'(pdb_r)
              + (cpit_pkg::DPR_W+2)'(pdc_r);
    den_nxt = cpit_pkg::DEN_W'(dsum) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      den_r <= den_nxt;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      qx3_r <= qx2_r;
      qy3_r <= qy2_r;
    end
  end

  // stage 4: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      nmx_r  <= nx_r[cpit_pkg::NUM_W-1] ? cpit_pkg::NUM_W'(-nx_r) : cpit_pkg::NUM_W'(nx_r);
      nmy_r  <= ny_r[cpit_pkg::NUM_W-1] ? cpit_pkg::NUM_W'(-ny_r) : cpit_pkg::NUM_W'(ny_r);
      dm_r   <= den_r[cpit_pkg::DEN_W-1] ? cpit_pkg::DEN_W'(-den_r)
                                         : cpit_pkg::DEN_W'(den_r);
      negx_r <= nx_r[cpit_pkg::NUM_W-1] ^ den_r[cpit_pkg::DEN_W-1];
      negy_r <= ny_r[cpit_pkg::NUM_W-1] ^ den_r[cpit_pkg::DEN_W-1];
      zero_r <= (den_r == '0);
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;
      qx4_r  <= qx3_r;
      qy4_r  <= qy3_r;
    end
  end

  // stage 5: overflow when quotient needs more than 32 bits; seed remainder
  always_comb begin
    rec_nxt.zero  = zero_r;
    rec_nxt.neg_x = negx_r;
    rec_nxt.neg_y = negy_r;
    rec_nxt.ovf_x = ((cpit_pkg::DEN_W+cpit_pkg::QUO_W)'(nmx_r) >= {dm_r, {cpit_pkg::QUO_W{1'b0}}});
    rec_nxt.ovf_y = ((cpit_pkg::DEN_W+cpit_pkg::QUO_W)'(nmy_r) >= {dm_r, {cpit_pkg::QUO_W{1'b0}}});
    rec_nxt.dmag  = dm_r;
    rec_nxt.rem_x = cpit_pkg::DEN_W'(nmx_r[cpit_pkg::NUM_W-1:cpit_pkg::QUO_W]);
    rec_nxt.rem_y = cpit_pkg::DEN_W'(nmy_r[cpit_pkg::NUM_W-1:cpit_pkg::QUO_W]);
    rec_nxt.lo_x  = nmx_r[cpit_pkg::QUO_W-1:0];
    rec_nxt.lo_y  = nmy_r[cpit_pkg::QUO_W-1:0];
    rec_nxt.quo_x = '0;
    rec_nxt.quo_y = '0;
    rec_nxt.ax    = ax4_r;
    rec_nxt.ay    = ay4_r;
    rec_nxt.qx    = qx4_r;
    rec_nxt.qy    = qy4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_rec   = rec_r;

endmodule

FILE: hdl/cpit_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpit_divider
// Pipelined restoring divider for both center coordinates, two quotient
// bits per stage, with the side record carried along.
// ----------------------------------------------------------------------------
module cpit_divider (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  cpit_pkg::div_t in_rec,
  output logic           out_valid,
  output cpit_pkg::div_t out_rec
);

  logic           v_r  [cpit_pkg::DIV_STAGES];
  cpit_pkg::div_t st_r [cpit_pkg::DIV_STAGES];

  // the restoring steps of one divider stage on one lane
  function automatic logic [cpit_pkg::DEN_W+2*cpit_pkg::QUO_W-1:0] div_bits(
    input logic [cpit_pkg::DEN_W-1:0] d,
    input logic [cpit_pkg::DEN_W-1:0] rem,
    input logic [cpit_pkg::QUO_W-1:0] lo,
    input logic [cpit_pkg::QUO_W-1:0] quo
  );
    logic [cpit_pkg::DEN_W:0]   t;
    logic [cpit_pkg::DEN_W-1:0] r;
    logic [cpit_pkg::QUO_W-1:0] l, q;
    r = rem;
    l = lo;
    q = quo;
    for (int j = 0; j < cpit_pkg::DIV_STEPS; j++) begin
      t = {r, l[cpit_pkg::QUO_W-1]};
      l = {l[cpit_pkg::QUO_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r = cpit_pkg::DEN_W'(t - {1'b0, d});
        q = {q[cpit_pkg::QUO_W-2:0], 1'b1};
      end else begin
        r = t[cpit_pkg::DEN_W-1:0];
        q = {q[cpit_pkg::QUO_W-2:0], 1'b0};
      end
    end
    return {r, l, q};
  endfunction

  function automatic cpit_pkg::div_t div_step(input cpit_pkg::div_t s);
    cpit_pkg::div_t o;
    o = s;
    {o.rem_x, o.lo_x, o.quo_x} = div_bits(s.dmag, s.rem_x, s.lo_x, s.quo_x);
    {o.rem_y, o.lo_y, o.quo_y} = div_bits(s.dmag, s.rem_y, s.lo_y, s.quo_y);
    return o;
  endfunction

  // advance the stage chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < cpit_pkg::DIV_STAGES; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < cpit_pkg::DIV_STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(in_rec);
      for (int k = 1; k < cpit_pkg::DIV_STAGES; k++) st_r[k] <= div_step(st_r[k-1]);
    end
  end

  assign out_valid = v_r[cpit_pkg::DIV_STAGES-1];
  assign out_rec   = st_r[cpit_pkg::DIV_STAGES-1];

endmodule

FILE: hdl/cpit_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpit_back
// Five stages: saturate center, offsets, squares, distance sums, band
// decision into the output register.
// ----------------------------------------------------------------------------
module cpit_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [cpit_pkg::TOL_W-1:0]   tolerance,
  input  logic                         in_valid,
  input  cpit_pkg::div_t               in_rec,
  output logic                         out_valid,
  output cpit_pkg::res_t               out_res
);

  localparam logic signed [cpit_pkg::CEN_W-1:0] CEN_MAX = {1'b0, {(cpit_pkg::CEN_W-1){1'b1}}};
  localparam logic signed [cpit_pkg::CEN_W-1:0] CEN_MIN = {1'b1, {(cpit_pkg::CEN_W-1){1'b0}}};
  localparam logic [cpit_pkg::QUO_W-1:0]        Q_HALF  = {1'b1, {(cpit_pkg::QUO_W-1){1'b0}}};

  logic                                v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [cpit_pkg::CEN_W-1:0]   cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r, cx4_r, cy4_r;
  logic                                z1_r, z2_r, z3_r, z4_r;
  cpit_pkg::coord_t                    ax1_r, ay1_r, qx1_r, qy1_r;
  logic [cpit_pkg::MAG_W-1:0]          mrx_r, mry_r, mdx_r, mdy_r;
  logic                                tie2_r, tie3_r, tie4_r;
  logic [cpit_pkg::SQD_W-1:0]          srx_r, sry_r, sdx_r, sdy_r;
  logic [cpit_pkg::DST_W-1:0]          r2_r, d2_r;
  cpit_pkg::res_t                      res_r, res_nxt;

  logic signed [cpit_pkg::MAG_W-1:0]   erx, ery, edx, edy;
  logic signed [cpit_pkg::CEN_W-1:0]   qxw, qyw;
  logic                                inside_c, outside_c;

  // signed quotient with saturation to the center range
  function automatic logic signed [cpit_pkg::CEN_W-1:0] sat_q(
    input logic neg, input logic ovf, input logic [cpit_pkg::QUO_W-1:0] q
  );
    logic signed [cpit_pkg::CEN_W-1:0] r;
    if (neg) begin
      r = (ovf || q > Q_HALF) ? CEN_MIN : cpit_pkg::CEN_W'(-$signed(q));
    end else begin
      r = (ovf || q >= Q_HALF) ? CEN_MAX : $signed(q);
    end
    return r;
  endfunction

  function automatic logic [cpit_pkg::MAG_W-1:0] mag(
    input logic signed [cpit_pkg::MAG_W-1:0] v
  );
    return v[cpit_pkg::MAG_W-1] ? cpit_pkg::MAG_W'(-v) : cpit_pkg::MAG_W'(v);
  endfunction

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: saturate the quotients
  always_ff @(posedge clk) begin
    if (en) begin
      cx1_r <= sat_q(in_rec.neg_x, in_rec.ovf_x, in_rec.quo_x);
      cy1_r <= sat_q(in_rec.neg_y, in_rec.ovf_y, in_rec.quo_y);
      z1_r  <= in_rec.zero;
      ax1_r <= in_rec.ax;
      ay1_r <= in_rec.ay;
      qx1_r <= in_rec.qx;
      qy1_r <= in_rec.qy;
    end
  end

  // stage 2: offsets to vertex a and to the query point; tie-break order
  always_comb begin
    erx = cpit_pkg::MAG_W'(cx1_r) - cpit_pkg::MAG_W'(ax1_r);
    ery = cpit_pkg::MAG_W'(cy1_r) - cpit_pkg::MAG_W'(ay1_r);
    edx = cpit_pkg::MAG_W'(qx1_r) - cpit_pkg::MAG_W'(cx1_r);
    edy = cpit_pkg::MAG_W'(qy1_r) - cpit_pkg::MAG_W'(cy1_r);
    qxw = cpit_pkg::CEN_W'(qx1_r);
    qyw = cpit_pkg::CEN_W'(qy1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mrx_r  <= mag(erx);
      mry_r  <= mag(ery);
      mdx_r  <= mag(edx);
      mdy_r  <= mag(edy);
      tie2_r <= (qxw < cx1_r) || (qxw == cx1_r && qyw < cy1_r);
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      z2_r   <= z1_r;
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (en) begin
      srx_r  <= mrx_r * mrx_r;
      sry_r  <= mry_r * mry_r;
      sdx_r  <= mdx_r * mdx_r;
      sdy_r  <= mdy_r * mdy_r;
      tie3_r <= tie2_r;
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
      z3_r   <= z2_r;
    end
  end

  // stage 4: squared radius and squared query distance
  always_ff @(posedge clk) begin
    if (en) begin
      r2_r   <= cpit_pkg::DST_W'(srx_r) + cpit_pkg::DST_W'(sry_r);
      d2_r   <= cpit_pkg::DST_W'(sdx_r) + cpit_pkg::DST_W'(sdy_r);
      tie4_r <= tie3_r;
      cx4_r  <= cx3_r;
      cy4_r  <= cy3_r;
      z4_r   <= z3_r;
    end
  end

  // stage 5: band decision, radius saturation, collinear override
  always_comb begin
    inside_c  = (cpit_pkg::CMP_W'(d2_r) + cpit_pkg::CMP_W'(tolerance)) < cpit_pkg::CMP_W'(r2_r);
    outside_c = (cpit_pkg::CMP_W'(r2_r) + cpit_pkg::CMP_W'(tolerance)) < cpit_pkg::CMP_W'(d2_r);
    res_nxt.degenerate     = z4_r;
    res_nxt.center_x       = cx4_r;
    res_nxt.center_y       = cy4_r;
    res_nxt.in_band        = !inside_c && !outside_c;
    res_nxt.inside_res     = inside_c || (!outside_c && tie4_r);
    res_nxt.radius_squared = (r2_r[cpit_pkg::DST_W-1:cpit_pkg::RAD_W] != '0)
                             ? {cpit_pkg::RAD_W{1'b1}} : r2_r[cpit_pkg::RAD_W-1:0];
    if (z4_r) begin
      res_nxt.center_x       = '0;
      res_nxt.center_y       = '0;
      res_nxt.in_band        = 1'b0;
      res_nxt.inside_res     = 1'b0;
      res_nxt.radius_squared = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_res   = res_r;

endmodule

FILE: hdl/circumcircle_point_inside_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcircle_point_inside_test_core
// In-circle test of a query point against a triangle's circumcircle.
// ----------------------------------------------------------------------------
// Takes one triangle plus query point per cycle unless the output stalls, and
// returns one result per item, in order, through five front stages (squares,
// products, determinant sums, magnitudes, overflow check), a sixteen-stage
// divider retiring two quotient bits per stage for both center coordinates,
// and five back stages ending in the output register. The whole pipeline
// holds while a result waits on the output; in_ready is out_ready OR no valid
// result, combinationally. Tolerance is written over the APB port at address 0.
module circumcircle_point_inside_test_core (
  input  logic                           clk,
  input  logic                           rst_n,
  cpit_in_if.sink                        in_ch,
  cpit_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cpit_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [cpit_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [cpit_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  logic [cpit_pkg::TOL_W-1:0] tol_r;
  logic                       adv;
  logic                       fr_valid, dv_valid, res_valid;
  cpit_pkg::div_t             fr_rec, dv_rec;
  cpit_pkg::res_t             res;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == cpit_pkg::REG_TOLERANCE) begin
      tol_r <= cfg_pwdata[cpit_pkg::TOL_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == cpit_pkg::REG_TOLERANCE)
                      ? cpit_pkg::APB_DW'(tol_r) : '0;

  // hold everything while the output beat is stuck
  assign adv         = !res_valid || out_ch.ready;
  assign in_ch.ready = adv;

  cpit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_ch.valid),
    .ax_i      (in_ch.vertex_a_x),
    .ay_i      (in_ch.vertex_a_y),
    .bx_i      (in_ch.vertex_b_x),
    .by_i      (in_ch.vertex_b_y),
    .cx_i      (in_ch.vertex_c_x),
    .cy_i      (in_ch.vertex_c_y),
    .qx_i      (in_ch.query_x),
    .qy_i      (in_ch.query_y),
    .out_valid (fr_valid),
    .out_rec   (fr_rec)
  );

  cpit_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_rec    (fr_rec),
    .out_valid (dv_valid),
    .out_rec   (dv_rec)
  );

  cpit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .tolerance (tol_r),
    .in_valid  (dv_valid),
    .in_rec    (dv_rec),
    .out_valid (res_valid),
    .out_res   (res)
  );

  // drive the result beat
  assign out_ch.valid          = res_valid;
  assign out_ch.inside_res     = res.inside_res;
  assign out_ch.in_band        = res.in_band;
  assign out_ch.degenerate     = res.degenerate;
  assign out_ch.center_x       = res.center_x;
  assign out_ch.center_y       = res.center_y;
  assign out_ch.radius_squared = res.radius_squared;

`ifndef SYNTHESIS
  // collinear result reports outside with zeroed geometry
  a_degen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.degenerate) |-> (!out_ch.inside_res && !out_ch.in_band
      && out_ch.radius_squared == '0 && out_ch.center_x == '0))
    else $error("degenerate result carries nonzero fields");

  // a stall freezes the divider output stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv) |=> ($stable(dv_valid) && $stable(dv_rec)))
    else $error("divider moved during a stall");

  // a tie-break decision never comes with a collinear triangle
  a_band_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.in_band && out_ch.degenerate))
    else $error("band decision on degenerate triangle");
`endif

endmodule

FILE: tb/tb_circumcircle_point_inside_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circumcircle_point_inside_test_core
// Self-checking bench for the circumcircle in-circle test core.
// ----------------------------------------------------------------------------
// Drives triangle/query beats with random gaps, applies output backpressure
// (including one long hold-off that fills the pipeline), and checks every
// result beat against an exact wide-integer predictor of the circumcenter,
// squared radius and inside/band decision. Tolerance is swept over APB
// between phases while the core is idle.
module tb_circumcircle_point_inside_test_core;

  typedef struct packed {
    cpit_pkg::coord_t ax, ay, bx, by, cx, cy, qx, qy;
  } tri_query_t;

  localparam logic signed [127:0] SAT63 = 128'sh7FFF_FFFF_FFFF_FFFF;

  class incircle_scoreboard;
    cpit_pkg::res_t                  expected_q[$];
    logic [cpit_pkg::TOL_W-1:0]      tolerance;
    int                              errors;

    function new();
      tolerance = '0;
      errors    = 0;
    endfunction

    // Saturate a quotient to signed 32 bits
    function longint sat32(logic signed [127:0] q);
      if (q > 128'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (q < -128'sh8000_0000) return -64'sh8000_0000;
      return longint'(q);
    endfunction

    function cpit_pkg::res_t predict_incircle(tri_query_t it);
      longint ax, ay, bx, by, cx, cy, qx, qy, da, db, dc, den, ctx, cty;
      logic signed [127:0] nx, ny, dw, r2, d2, tw;
      cpit_pkg::res_t r;
      ax = it.ax; ay = it.ay; bx = it.bx; by = it.by;
      cx = it.cx; cy = it.cy; qx = it.qx; qy = it.qy;
      r = '0;
      den = 2 * (ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
      if (den == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      da = ax * ax + ay * ay;
      db = bx * bx + by * by;
      dc = cx * cx + cy * cy;
      nx = da * (cy - by) + db * (ay - cy) + dc * (by - ay);
      ny = -(da * (cx - bx) + db * (ax - cx) + dc * (bx - ax));
      dw = den;
      ctx = sat32(nx / dw);
      cty = sat32(ny / dw);
      r2 = (ctx - ax) * (ctx - ax) + (cty - ay) * (cty - ay);
      d2 = (qx - ctx) * (qx - ctx) + (qy - cty) * (qy - cty);
      tw = tolerance;
      if (d2 + tw < r2) begin
        r.inside_res = 1'b1;
      end else if (r2 + tw < d2) begin
        r.inside_res = 1'b0;
      end else begin
        r.in_band    = 1'b1;
        r.inside_res = (qx < ctx) || (qx == ctx && qy < cty);
      end
      r.center_x = ctx[31:0];
      r.center_y = cty[31:0];
      r.radius_squared = (r2 > SAT63) ? SAT63[62:0] : r2[62:0];
      return r;
    endfunction

    function void note_input(tri_query_t it);
      expected_q.insert(expected_q.size(), predict_incircle(it));
    endfunction

    function void check_result(cpit_pkg::res_t got);
      cpit_pkg::res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (got.inside_res !== e.inside_res) begin
        $error("inside_res exp %0d got %0d", e.inside_res, got.inside_res); errors++;
      end
      if (got.in_band !== e.in_band) begin
        $error("in_band exp %0d got %0d", e.in_band, got.in_band); errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $error("degenerate exp %0d got %0d", e.degenerate, got.degenerate); errors++;
      end
      if (got.center_x !== e.center_x) begin
        $error("center_x exp %0d got %0d", e.center_x, got.center_x); errors++;
      end
      if (got.center_y !== e.center_y) begin
        $error("center_y exp %0d got %0d", e.center_y, got.center_y); errors++;
      end
      if (got.radius_squared !== e.radius_squared) begin
        $error("radius_squared exp %0d got %0d", e.radius_squared, got.radius_squared);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [cpit_pkg::APB_AW-1:0] cfg_paddr = '0;
  logic [cpit_pkg::APB_DW-1:0] cfg_pwdata = '0;
  logic [cpit_pkg::APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  cpit_in_if  in_ch();
  cpit_out_if out_ch();

  circumcircle_point_inside_test_core uut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  incircle_scoreboard sb = new();
  bit quiet = 1'b0;       // no random idling on either side
  bit hold_req = 1'b0;    // ask the receiver for a long hold-off
  int hold_left = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.vertex_a_x, in_ch.vertex_a_y, in_ch.vertex_b_x, in_ch.vertex_b_y,
     in_ch.vertex_c_x, in_ch.vertex_c_y, in_ch.query_x, in_ch.query_y} = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: check accepted result beats, then pick next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.inside_res, out_ch.in_band, out_ch.degenerate,
                         out_ch.center_x, out_ch.center_y, out_ch.radius_squared});
      if (hold_req && hold_left == 0) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic apb_write(input logic [cpit_pkg::APB_AW-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.tolerance = data[cpit_pkg::TOL_W-1:0];
  endtask

  // Drain the pipeline, then write the tolerance
  task automatic set_tolerance(input logic [cpit_pkg::TOL_W-1:0] tol);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    apb_write(cpit_pkg::REG_TOLERANCE, {16'h0, tol});
  endtask

  // Offer one beat; returns after the accepting edge and any random idle gap
  task automatic send_beat(input tri_query_t it);
    in_ch.valid <= 1'b1;
    in_ch.vertex_a_x <= it.ax; in_ch.vertex_a_y <= it.ay;
    in_ch.vertex_b_x <= it.bx; in_ch.vertex_b_y <= it.by;
    in_ch.vertex_c_x <= it.cx; in_ch.vertex_c_y <= it.cy;
    in_ch.query_x <= it.qx; in_ch.query_y <= it.qy;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    if (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic cpit_pkg::coord_t rnd_coord(int span);
    if (span == 0) return cpit_pkg::coord_t'($urandom);
    return cpit_pkg::coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic tri_query_t rnd_item();
    tri_query_t it;
    int span, kind;
    kind = $urandom_range(9);
    span = (kind < 3) ? 0 : (kind < 7) ? 64 : 2000;
    it = {rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span),
          rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span)};
    case ($urandom_range(9))
      0: begin it.qx = it.ax; it.qy = it.ay; end          // on the circle
      1: begin it.cx = it.bx; it.cy = it.by; end          // collinear
      2: begin it.qx = it.qx >>> 3; it.qy = it.qy >>> 3; end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    logic [cpit_pkg::TOL_W-1:0] tols [5];
    tols = '{16'd0, 16'hFFFF, 16'd1, 16'd4000, 16'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, degenerate, inside/outside/band, overflow
    set_tolerance(16'd0);
    send_beat({8{16'sh8000}});
    send_beat({8{16'sh7FFF}});
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0});
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd100, 16'sd0});
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, -16'sd16, 16'sd0});
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd0});
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd0, -16'sd16});
    send_beat({16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE,
               16'sh7FFF, 16'sh8000});
    send_beat({16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001,
               16'sh7FFF, 16'sh7FFF});
    send_beat({16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh7FFE,
               16'sh0000, 16'sh0000});
    send_beat({16'sd1, 16'sd2, 16'sd3, 16'sd6, 16'sd5, 16'sd10, 16'sd0, 16'sd0});
    send_beat({16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
               16'sh8000, 16'sh8000});
    set_tolerance(16'hFFFF);
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd20, 16'sd0});
    send_beat({-16'sd16, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, -16'sd20, 16'sd0});
    send_beat({16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE,
               16'sh7FFF, 16'sh8000});

    // Random phases across tolerance settings
    foreach (tols[p]) begin
      set_tolerance(p == 3 ? 16'($urandom) : tols[p]);
      quiet = (p == 2);
      for (int i = 0; i < 110; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        if (p == 3 && i == 50) begin
          in_ch.valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_beat(rnd_item());
      end
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
